### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared sizes and types of the sufferage task scheduler core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int MAX_MACHINES = 8;
  localparam int MAX_TASKS    = 64;
  localparam int TIME_W       = 16;
  localparam int CT_W         = 22;
  localparam int M_W          = $clog2(MAX_MACHINES);
  localparam int T_W          = $clog2(MAX_TASKS);
  localparam int MC_W         = 4;
  localparam int TC_W         = 7;
  localparam int ADDR_W       = M_W + T_W;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // register indexes
  localparam logic REG_MACHINES = 1'b0;
  localparam logic REG_TASKS    = 1'b1;

  typedef struct packed {
    logic [MC_W-1:0] machines;   // effective count, 1..MAX_MACHINES
    logic [TC_W-1:0] tasks;      // effective count, 1..MAX_TASKS
    logic            restart;
  } cfg_t;

  typedef struct packed {
    logic           valid;
    logic           first;
    logic           last_m;
    logic [M_W-1:0] mach;
    logic [T_W-1:0] tsk;
  } rd_tag_t;

endpackage

### rtl/core/sts_cfg_regs.sv
// ----------------------------------------------------------------------------
// sts_cfg_regs
// APB register file holding machine and task counts, with clamping.
// ----------------------------------------------------------------------------
module sts_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [sts_pkg::PDATA_W-1:0] pwdata,
  output logic [sts_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output sts_pkg::cfg_t               cfg
);

  logic [sts_pkg::MC_W-1:0] machine_count_r;
  logic [sts_pkg::TC_W-1:0] task_count_r;
  logic                     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machine_count_r <= sts_pkg::MC_W'(sts_pkg::MAX_MACHINES);
      task_count_r    <= sts_pkg::TC_W'(sts_pkg::MAX_TASKS);
    end else if (wr_en) begin
      case (paddr[2])
        sts_pkg::REG_MACHINES: machine_count_r <= pwdata[sts_pkg::MC_W-1:0];
        sts_pkg::REG_TASKS:    task_count_r    <= pwdata[sts_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sts_pkg::REG_MACHINES: prdata = sts_pkg::PDATA_W'(machine_count_r);
      sts_pkg::REG_TASKS:    prdata = sts_pkg::PDATA_W'(task_count_r);
      default:               prdata = '0;
    endcase
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (machine_count_r == '0)
      cfg.machines = sts_pkg::MC_W'(1);
    else if (machine_count_r > sts_pkg::MC_W'(sts_pkg::MAX_MACHINES))
      cfg.machines = sts_pkg::MC_W'(sts_pkg::MAX_MACHINES);
    else
      cfg.machines = machine_count_r;
    if (task_count_r == '0)
      cfg.tasks = sts_pkg::TC_W'(1);
    else if (task_count_r > sts_pkg::TC_W'(sts_pkg::MAX_TASKS))
      cfg.tasks = sts_pkg::TC_W'(sts_pkg::MAX_TASKS);
    else
      cfg.tasks = task_count_r;
    cfg.restart = wr_en;
  end

endmodule

### rtl/core/sts_tables.sv
// ----------------------------------------------------------------------------
// sts_tables
// Execution-time and completion-time memories, one write and one
// registered read port each, entry (m, t) at address {m, t}.
// ----------------------------------------------------------------------------
module sts_tables (
  input  logic                       clk,
  input  logic                       ex_we,
  input  logic [sts_pkg::ADDR_W-1:0] ex_waddr,
  input  logic [sts_pkg::TIME_W-1:0] ex_wdata,
  input  logic [sts_pkg::ADDR_W-1:0] ex_raddr,
  output logic [sts_pkg::TIME_W-1:0] ex_rdata,
  input  logic                       ct_we,
  input  logic [sts_pkg::ADDR_W-1:0] ct_waddr,
  input  logic [sts_pkg::CT_W-1:0]   ct_wdata,
  input  logic [sts_pkg::ADDR_W-1:0] ct_raddr,
  output logic [sts_pkg::CT_W-1:0]   ct_rdata
);

  localparam int DEPTH = sts_pkg::MAX_MACHINES * sts_pkg::MAX_TASKS;

  logic [sts_pkg::TIME_W-1:0] ex_mem [DEPTH];
  logic [sts_pkg::CT_W-1:0]   ct_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ex_we) begin
      ex_mem[ex_waddr] <= ex_wdata;
    end
    ex_rdata <= ex_mem[ex_raddr];
  end

  always_ff @(posedge clk) begin
    if (ct_we) begin
      ct_mem[ct_waddr] <= ct_wdata;
    end
    ct_rdata <= ct_mem[ct_raddr];
  end

endmodule

### rtl/core/sts_eval_unit.sv
// ----------------------------------------------------------------------------
// sts_eval_unit
// Shared compare unit: folds one completion time a cycle into the best and
// second-best of the current task, then ranks the task's sufferage.
// ----------------------------------------------------------------------------
module sts_eval_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  sts_pkg::rd_tag_t          tag,
  input  logic [sts_pkg::CT_W-1:0]  rdata,
  output logic [sts_pkg::T_W-1:0]   best_task,
  output logic [sts_pkg::M_W-1:0]   best_mach,
  output logic [sts_pkg::CT_W-1:0]  best_time,
  output logic                      idle
);

  localparam int SUFF_W = sts_pkg::CT_W + 1;

  logic [sts_pkg::CT_W-1:0] mn_r, mn_nxt;
  logic [sts_pkg::CT_W-1:0] sec_r, sec_nxt;
  logic                     has_sec_r, has_sec_nxt;
  logic [sts_pkg::M_W-1:0]  pos_r, pos_nxt;
  logic [SUFF_W-1:0]        suff;

  logic                     cand_v_r;
  logic [SUFF_W-1:0]        cand_suff_r;
  logic [sts_pkg::T_W-1:0]  cand_task_r;
  logic [sts_pkg::M_W-1:0]  cand_mach_r;
  logic [sts_pkg::CT_W-1:0] cand_time_r;

  logic                     found_r;
  logic [SUFF_W-1:0]        best_suff_r;
  logic [sts_pkg::T_W-1:0]  best_task_r;
  logic [sts_pkg::M_W-1:0]  best_mach_r;
  logic [sts_pkg::CT_W-1:0] best_time_r;

  always_comb begin
    mn_nxt      = mn_r;
    sec_nxt     = sec_r;
    has_sec_nxt = has_sec_r;
    pos_nxt     = pos_r;
    if (tag.first) begin
      mn_nxt      = rdata;
      pos_nxt     = tag.mach;
      has_sec_nxt = 1'b0;
    end else if (rdata < mn_r) begin
      sec_nxt     = mn_r;
      has_sec_nxt = 1'b1;
      mn_nxt      = rdata;
      pos_nxt     = tag.mach;
    end else if (rdata != mn_r && (!has_sec_r || rdata < sec_r)) begin
      sec_nxt     = rdata;
      has_sec_nxt = 1'b1;
    end
    // no distinct second value ranks above every real difference
    suff = has_sec_nxt ? {1'b0, sec_nxt - mn_nxt} : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      cand_v_r <= tag.valid && tag.last_m;
      if (clear)
        found_r <= 1'b0;
      else if (cand_v_r)
        found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      mn_r      <= mn_nxt;
      sec_r     <= sec_nxt;
      has_sec_r <= has_sec_nxt;
      pos_r     <= pos_nxt;
    end
    if (tag.valid && tag.last_m) begin
      cand_suff_r <= suff;
      cand_task_r <= tag.tsk;
      cand_mach_r <= pos_nxt;
      cand_time_r <= mn_nxt;
    end
    // strict compare keeps the first task on a tie
    if (cand_v_r && (!found_r || cand_suff_r > best_suff_r)) begin
      best_suff_r <= cand_suff_r;
      best_task_r <= cand_task_r;
      best_mach_r <= cand_mach_r;
      best_time_r <= cand_time_r;
    end
  end

  assign best_task = best_task_r;
  assign best_mach = best_mach_r;
  assign best_time = best_time_r;
  assign idle      = !tag.valid && !cand_v_r;

endmodule

### rtl/core/sufferage_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// sufferage_task_scheduler_core
// Sufferage list scheduler over an execution-time matrix loaded one entry
// per request, machine by machine.
// ----------------------------------------------------------------------------
// A request loads one matrix entry; busy stays low while loading. The
// request carrying the last entry starts the schedule, and busy stays high
// until the update walk of the final round has finished. Each round scans
// the completion memory one entry a cycle through a single compare unit,
// pausing to skip each assigned task without a read. It then drains the
// compare unit, picks and reports a task, and walks the tasks to add its
// time to the chosen machine's completion times of the unassigned tasks,
// ending with the walk's last write.
// Each result is presented for exactly one cycle with out_valid and cannot
// be held off by the receiver; results never come on consecutive cycles,
// and the last is marked by out_last.
// ----------------------------------------------------------------------------
module sufferage_task_scheduler_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sts_pkg::TIME_W-1:0]  in_exec_time,
  output logic                        out_valid,
  output logic [sts_pkg::T_W-1:0]     out_task_index,
  output logic [sts_pkg::M_W-1:0]     out_machine_index,
  output logic [sts_pkg::TIME_W-1:0]  out_task_time,
  output logic [sts_pkg::CT_W-1:0]    out_makespan,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [sts_pkg::PDATA_W-1:0] pwdata,
  output logic [sts_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_UDRAIN = 3'd5;

  localparam int M_W  = sts_pkg::M_W;
  localparam int T_W  = sts_pkg::T_W;
  localparam int CT_W = sts_pkg::CT_W;

  sts_pkg::cfg_t    cfg;
  sts_pkg::rd_tag_t tag_r, tag_nxt;

  logic [2:0]                 state_r, state_nxt;
  logic [M_W-1:0]             lm_r, lm_nxt;
  logic [T_W-1:0]             lt_r, lt_nxt;
  logic [T_W-1:0]             round_r, round_nxt;
  logic [T_W-1:0]             st_t_r, st_t_nxt;
  logic [M_W-1:0]             st_m_r, st_m_nxt;
  logic                       issue_done_r, issue_done_nxt;
  logic [sts_pkg::MAX_TASKS-1:0] flags_r, flags_nxt;
  logic [CT_W-1:0]            makespan_r, makespan_nxt;
  logic [sts_pkg::TIME_W-1:0] add_r, add_nxt;
  logic [T_W-1:0]             ut_r, ut_nxt;
  logic                       wtag_v_r, wtag_v_nxt;
  logic [T_W-1:0]             wtag_t_r, wtag_t_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [T_W-1:0]             out_task_r;
  logic [M_W-1:0]             out_mach_r;
  logic [sts_pkg::TIME_W-1:0] out_time_r;
  logic [CT_W-1:0]            out_span_r;
  logic                       out_last_r;

  logic [sts_pkg::MC_W-1:0]   machines_m1;
  logic [sts_pkg::TC_W-1:0]   tasks_m1;
  logic                       lm_last, lt_last, st_m_last, st_t_last, ut_last, round_last;

  logic                         ex_we, ct_we, ld_we;
  logic [sts_pkg::ADDR_W-1:0]   ex_waddr, ex_raddr, ct_waddr, ct_raddr;
  logic [sts_pkg::TIME_W-1:0]   ex_wdata, ex_rdata;
  logic [CT_W-1:0]              ct_wdata, ct_rdata, upd_wdata;
  logic [CT_W:0]                upd_sum;

  logic                         eval_clear, eval_idle;
  logic [T_W-1:0]               best_task;
  logic [M_W-1:0]               best_mach;
  logic [CT_W-1:0]              best_time;

  sts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sts_tables u_tables (
    .clk      (clk),
    .ex_we    (ex_we),
    .ex_waddr (ex_waddr),
    .ex_wdata (ex_wdata),
    .ex_raddr (ex_raddr),
    .ex_rdata (ex_rdata),
    .ct_we    (ct_we),
    .ct_waddr (ct_waddr),
    .ct_wdata (ct_wdata),
    .ct_raddr (ct_raddr),
    .ct_rdata (ct_rdata)
  );

  sts_eval_unit u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (eval_clear),
    .tag       (tag_r),
    .rdata     (ct_rdata),
    .best_task (best_task),
    .best_mach (best_mach),
    .best_time (best_time),
    .idle      (eval_idle)
  );

  assign machines_m1 = cfg.machines - sts_pkg::MC_W'(1);
  assign tasks_m1    = cfg.tasks - sts_pkg::TC_W'(1);
  assign lm_last     = sts_pkg::MC_W'(lm_r) == machines_m1;
  assign st_m_last   = sts_pkg::MC_W'(st_m_r) == machines_m1;
  assign lt_last     = sts_pkg::TC_W'(lt_r) == tasks_m1;
  assign st_t_last   = sts_pkg::TC_W'(st_t_r) == tasks_m1;
  assign ut_last     = sts_pkg::TC_W'(ut_r) == tasks_m1;
  assign round_last  = sts_pkg::TC_W'(round_r) == tasks_m1;

  // saturating add of the assigned task's time on the chosen machine
  assign upd_sum   = {1'b0, ct_rdata} + (CT_W + 1)'(add_r);
  assign upd_wdata = upd_sum[CT_W] ? '1 : upd_sum[CT_W-1:0];

  assign ld_we    = (state_r == S_IDLE) && start;
  assign ex_we    = ld_we;
  assign ex_waddr = {lm_r, lt_r};
  assign ex_wdata = in_exec_time;
  assign ex_raddr = {best_mach, best_task};

  always_comb begin
    ct_we    = 1'b0;
    ct_waddr = {lm_r, lt_r};
    ct_wdata = CT_W'(in_exec_time);
    if (ld_we) begin
      ct_we = 1'b1;
    end else if (wtag_v_r) begin
      ct_we    = 1'b1;
      ct_waddr = {best_mach, wtag_t_r};
      ct_wdata = upd_wdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    lm_nxt         = lm_r;
    lt_nxt         = lt_r;
    round_nxt      = round_r;
    st_t_nxt       = st_t_r;
    st_m_nxt       = st_m_r;
    issue_done_nxt = issue_done_r;
    flags_nxt      = flags_r;
    makespan_nxt   = makespan_r;
    add_nxt        = add_r;
    ut_nxt         = ut_r;
    wtag_v_nxt     = 1'b0;
    wtag_t_nxt     = wtag_t_r;
    out_valid_nxt  = 1'b0;
    tag_nxt        = '0;
    eval_clear     = 1'b0;
    ct_raddr       = {st_m_r, st_t_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (lt_last) begin
            lt_nxt = '0;
            if (lm_last) begin
              lm_nxt         = '0;
              round_nxt      = '0;
              flags_nxt      = '0;
              makespan_nxt   = '0;
              st_t_nxt       = '0;
              st_m_nxt       = '0;
              issue_done_nxt = 1'b0;
              eval_clear     = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              lm_nxt = lm_r + M_W'(1);
            end
          end else begin
            lt_nxt = lt_r + T_W'(1);
          end
        end
        if (cfg.restart) begin
          lm_nxt = '0;
          lt_nxt = '0;
        end
      end
      S_SCAN: begin
        if (!issue_done_r) begin
          if (flags_r[st_t_r]) begin
            // assigned task: skip without a read
            st_m_nxt = '0;
            if (st_t_last) issue_done_nxt = 1'b1;
            else           st_t_nxt       = st_t_r + T_W'(1);
          end else begin
            tag_nxt.valid  = 1'b1;
            tag_nxt.first  = (st_m_r == '0);
            tag_nxt.last_m = st_m_last;
            tag_nxt.mach   = st_m_r;
            tag_nxt.tsk    = st_t_r;
            if (st_m_last) begin
              st_m_nxt = '0;
              if (st_t_last) issue_done_nxt = 1'b1;
              else           st_t_nxt       = st_t_r + T_W'(1);
            end else begin
              st_m_nxt = st_m_r + M_W'(1);
            end
          end
        end else if (eval_idle) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        flags_nxt[best_task] = 1'b1;
        if (best_time > makespan_r) makespan_nxt = best_time;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        add_nxt       = ex_rdata;
        out_valid_nxt = 1'b1;
        ut_nxt        = '0;
        state_nxt     = S_UPD;
      end
      S_UPD: begin
        ct_raddr = {best_mach, ut_r};
        if (!flags_r[ut_r]) begin
          wtag_v_nxt = 1'b1;
          wtag_t_nxt = ut_r;
        end
        if (ut_last) state_nxt = S_UDRAIN;
        else         ut_nxt    = ut_r + T_W'(1);
      end
      S_UDRAIN: begin
        // last update write lands here, before the next scan reads
        if (round_last) begin
          state_nxt = S_IDLE;
        end else begin
          round_nxt      = round_r + T_W'(1);
          st_t_nxt       = '0;
          st_m_nxt       = '0;
          issue_done_nxt = 1'b0;
          eval_clear     = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lm_r         <= '0;
      lt_r         <= '0;
      round_r      <= '0;
      st_t_r       <= '0;
      st_m_r       <= '0;
      issue_done_r <= 1'b0;
      flags_r      <= '0;
      makespan_r   <= '0;
      ut_r         <= '0;
      wtag_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      tag_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      lm_r         <= lm_nxt;
      lt_r         <= lt_nxt;
      round_r      <= round_nxt;
      st_t_r       <= st_t_nxt;
      st_m_r       <= st_m_nxt;
      issue_done_r <= issue_done_nxt;
      flags_r      <= flags_nxt;
      makespan_r   <= makespan_nxt;
      ut_r         <= ut_nxt;
      wtag_v_r     <= wtag_v_nxt;
      out_valid_r  <= out_valid_nxt;
      tag_r        <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_r    <= add_nxt;
    wtag_t_r <= wtag_t_nxt;
    if (state_r == S_EXEC) begin
      out_task_r <= best_task;
      out_mach_r <= best_mach;
      out_time_r <= ex_rdata;
      out_span_r <= makespan_r;
      out_last_r <= round_last;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_task_index    = out_task_r;
  assign out_machine_index = out_mach_r;
  assign out_task_time     = out_time_r;
  assign out_makespan      = out_span_r;
  assign out_last          = out_last_r;

  // a result only leaves while the schedule is running
  a_out_in_sched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside schedule");

  // results never come on consecutive cycles
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

  // the picked task must still be unassigned
  a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> !flags_r[best_task])
    else $error("task assigned twice");

  // load and update never compete for the completion write port
  a_ct_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ld_we && wtag_v_r))
    else $error("completion write conflict");

endmodule
